>>> rtl/saft_pkg.sv
// shared types and constants for the sent angle frame tracker
package saft_pkg;

  localparam int NumWidth    = 36;
  localparam int DivWidth    = 32;
  localparam int DeltaWidth  = 14;
  localparam int AccWidth    = 34;
  localparam logic [23:0] SpeedScale = 24'd10000000;
  localparam logic signed [12:0] HalfTurn = 13'sd2048;
  localparam logic signed [13:0] FullTurn = 14'sd4096;
  localparam logic [3:0] NibbleMask = 4'hf;

  typedef enum logic [1:0] {
    CFG_DIRECTION  = 2'd0,
    CFG_RANGE_LOW  = 2'd1,
    CFG_RANGE_HIGH = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_WRAP,
    ST_DIV_WAIT,
    ST_SAT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [3:0]  angle_high_nibble;
    logic [3:0]  angle_mid_nibble;
    logic [3:0]  angle_low_nibble;
    logic [3:0]  counter_high_nibble;
    logic [3:0]  counter_low_nibble;
    logic [3:0]  check_nibble;
    logic [31:0] timestamp_us;
  } frame_in_t;

  typedef struct packed {
    logic               frame_ok;
    logic [11:0]        raw_angle;
    logic signed [31:0] turn_angle;
    logic signed [31:0] speed;
    logic [31:0]        missed_frames;
  } frame_out_t;

  typedef struct packed {
    logic                start;
    logic [NumWidth-1:0] dividend;
    logic [DivWidth-1:0] divisor;
  } div_req_t;

endpackage

>>> rtl/saft_div.sv
// bit-serial restoring unsigned divider, one quotient bit per cycle
module saft_div
  import saft_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  div_req_t            req,
  output logic                done,
  output logic [NumWidth-1:0] quotient
);

  localparam int NumW = NumWidth;
  localparam int DenW = DivWidth;
  localparam int CntW = $clog2(NumW);
  localparam logic [CntW-1:0] LastCount = CntW'(NumW - 1);

  logic [DenW-1:0] rem;
  logic [DenW-1:0] divisor;
  logic [NumW-1:0] quo;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   trial;
  logic            fits;

  always_comb begin
    trial = {rem, quo[NumW-1]} - {1'b0, divisor};
    fits  = ({rem, quo[NumW-1]} >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= LastCount;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= trial[DenW-1:0];
      end else begin
        rem <= {rem[DenW-2:0], quo[NumW-1]};
      end
      quo <= {quo[NumW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/sent_angle_frame_tracker_core.sv
// top level of the sent angle frame tracker
// states per frame: acc, wrap, div_wait and sat (nonzero time step only), out; a rejected or
// first frame goes straight to out. The bit-serial speed divider gives one quotient bit per
// cycle over 36 bits. One frame at a time, next taken the cycle after its result loads.
// rst is synchronous: configuration returns to direction 1 and clip range -2^23 .. 2^23-1,
// tracking state clears to zero
module sent_angle_frame_tracker_core
  import saft_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  frame_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output frame_out_t out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state, state_next;

  logic signed [1:0]  direction;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;

  logic        seen_any_frame;
  logic [7:0]  expected_counter;
  logic [31:0] missed_total;
  logic [11:0] last_angle_sample;
  logic        have_last_sample;
  logic [31:0] accumulated_angle;
  logic [31:0] speed_value;
  logic [31:0] last_time;

  logic                         ok_r;
  logic signed [DeltaWidth-1:0] dd;
  logic [31:0]                  dt;
  logic signed [AccWidth-1:0]   acc_sum;
  logic signed [AccWidth-1:0]   clip_range;
  logic [NumWidth-1:0]          num_mag;
  logic                         num_neg;

  logic accept;
  logic out_load;
  logic [7:0]  ct;
  logic [7:0]  exp_base;
  logic        ok;
  logic [11:0] raw;
  logic signed [12:0] d_raw;
  logic signed [12:0] d_unw;
  logic signed [DeltaWidth-1:0] d_dir;
  logic [12:0] dd_mag;
  logic [NumWidth-1:0] prod;
  logic signed [AccWidth-1:0] range_low_x;
  logic signed [AccWidth-1:0] range_high_x;

  div_req_t            div_req;
  logic                div_done;
  logic [NumWidth-1:0] div_quo;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign ct       = {in_data.counter_high_nibble, in_data.counter_low_nibble};
  assign exp_base = seen_any_frame ? expected_counter + 8'd1 : ct;
  assign ok       = ((~in_data.angle_high_nibble) & NibbleMask) == in_data.check_nibble;
  assign raw      = {in_data.angle_high_nibble, in_data.angle_mid_nibble,
                     in_data.angle_low_nibble};

  always_comb begin
    d_raw = $signed({1'b0, raw}) - $signed({1'b0, last_angle_sample});
    if (d_raw > HalfTurn) begin
      d_unw = 13'(d_raw - FullTurn);
    end else if (d_raw < -HalfTurn) begin
      d_unw = 13'(d_raw + FullTurn);
    end else begin
      d_unw = d_raw;
    end
    case (direction)
      2'sb01:  d_dir = DeltaWidth'(d_unw);
      2'sb11:  d_dir = -DeltaWidth'(d_unw);
      2'sb10:  d_dir = -(DeltaWidth'(d_unw) <<< 1);
      default: d_dir = '0;
    endcase
  end

  assign dd_mag       = dd[DeltaWidth-1] ? 13'(-dd) : 13'(dd);
  assign prod         = NumWidth'(SpeedScale) * NumWidth'(dd_mag);
  assign range_low_x  = AccWidth'(range_low);
  assign range_high_x = AccWidth'(range_high);

  assign div_req.start    = (state == ST_WRAP) && (dt != '0);
  assign div_req.dividend = num_mag;
  assign div_req.divisor  = dt;

  saft_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (ok && have_last_sample) ? ST_ACC : ST_OUT;
        end
      end
      ST_ACC: begin
        state_next = ST_WRAP;
      end
      ST_WRAP: begin
        state_next = (dt != '0) ? ST_DIV_WAIT : ST_OUT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= 2'sd1;
      range_low  <= -32'sd8388608;
      range_high <= 32'sd8388607;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DIRECTION:  direction  <= $signed(cfg_data[1:0]);
        CFG_RANGE_LOW:  range_low  <= $signed(cfg_data);
        CFG_RANGE_HIGH: range_high <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any_frame    <= 1'b0;
      expected_counter  <= '0;
      missed_total      <= '0;
      last_angle_sample <= '0;
      have_last_sample  <= 1'b0;
      accumulated_angle <= '0;
      speed_value       <= '0;
      last_time         <= '0;
      ok_r              <= 1'b0;
    end else begin
      if (accept) begin
        seen_any_frame   <= 1'b1;
        expected_counter <= ct;
        if (ct != exp_base) begin
          missed_total <= missed_total + {24'd0, 8'(ct - exp_base)};
        end
        ok_r <= ok;
        if (ok) begin
          last_angle_sample <= raw;
          have_last_sample  <= 1'b1;
          last_time         <= in_data.timestamp_us;
        end
      end
      if (state == ST_WRAP) begin
        if (acc_sum < range_low_x) begin
          accumulated_angle <= 32'(acc_sum + clip_range);
        end else if (acc_sum > range_high_x) begin
          accumulated_angle <= 32'(acc_sum - clip_range);
        end else begin
          accumulated_angle <= 32'(acc_sum);
        end
      end
      if (state == ST_SAT) begin
        if (!num_neg) begin
          speed_value <= (div_quo[NumWidth-1:31] != '0) ? 32'h7fff_ffff : div_quo[31:0];
        end else if (div_quo > NumWidth'(33'h0_8000_0000)) begin
          speed_value <= 32'h8000_0000;
        end else begin
          speed_value <= 32'(-div_quo);
        end
      end
    end
  end

  // datapath scratch registers
  always_ff @(posedge clk) begin
    if (accept) begin
      dd <= d_dir;
      dt <= in_data.timestamp_us - last_time;
    end
    if (state == ST_ACC) begin
      acc_sum    <= AccWidth'($signed(accumulated_angle)) + AccWidth'(dd);
      clip_range <= range_high_x - range_low_x + AccWidth'(1);
      num_mag    <= prod;
      num_neg    <= dd[DeltaWidth-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.frame_ok      <= ok_r;
      out_data.raw_angle     <= last_angle_sample;
      out_data.turn_angle    <= $signed(accumulated_angle);
      out_data.speed         <= $signed(speed_value);
      out_data.missed_frames <= missed_total;
    end
  end

endmodule

>>> test/sent_angle_frame_tracker_core_tb.sv
// testbench for the sent angle frame tracker: directed table, then random frames
`timescale 1ns / 100ps

module sent_angle_frame_tracker_core_tb
  import saft_pkg::*;
();

  localparam int NumPhases     = 9;
  localparam int FramesPerPhase = 210;
  localparam int CalmFrames    = 30;
  localparam int QuietLimit    = 3000;
  localparam int LongHold      = 400;
  localparam int HoldAfter     = 300;
  localparam int TailCycles    = 64;
  localparam int MaxLines      = 40;

  // fixed register setups for the first phases; later phases pick at random
  localparam int NumFixed = 6;
  localparam int PhaseDir [NumFixed] = '{1, -1, 0, -2, 1, 1};
  localparam logic [31:0] PhaseLo [NumFixed] =
    '{32'hff800000, 32'hffffff9c, 32'h80000000, 32'd0, 32'd1000, 32'h7fffffff};
  localparam logic [31:0] PhaseHi [NumFixed] =
    '{32'h007fffff, 32'd100, 32'h7fffffff, 32'd4095, 32'hfffffc18, 32'h80000000};

  typedef struct packed {
    logic [11:0] angle;
    logic [7:0]  ctr;
    logic [3:0]  chk;
    logic [31:0] ts;
    logic        typed;
    logic        ok;
    logic [11:0] raw;
    logic [31:0] turn;
    logic [31:0] spd;
    logic [31:0] miss;
  } probe_row_t;

  localparam probe_row_t ProbeRows [12] = '{
    // first frame, counter taken as is
    '{12'h000, 8'h00, 4'hf, 32'd1000, 1'b1, 1'b1, 12'h000, 32'd0, 32'd0, 32'd0},
    // check nibble wrong
    '{12'hfff, 8'h01, 4'hf, 32'd2000, 1'b1, 1'b0, 12'h000, 32'd0, 32'd0, 32'd0},
    // delta of exactly a half turn
    '{12'h800, 8'h02, 4'h7, 32'd2024, 1'b1, 1'b1, 12'h800, 32'd2048, 32'd20000000, 32'd0},
    // zero time step holds speed
    '{12'h000, 8'h03, 4'hf, 32'd2024, 1'b1, 1'b1, 12'h000, 32'd0, 32'd20000000, 32'd0},
    // counter skips ahead, angle wraps down
    '{12'hfff, 8'h10, 4'h0, 32'd2025, 1'b0, 1'b0, 12'h0, 32'd0, 32'd0, 32'd0},
    // counter goes back, timestamp goes back
    '{12'h001, 8'h05, 4'hf, 32'd2024, 1'b0, 1'b0, 12'h0, 32'd0, 32'd0, 32'd0},
    // speed saturates high
    '{12'h801, 8'h06, 4'h7, 32'd2025, 1'b1, 1'b1, 12'h801, 32'd2049, 32'h7fffffff, 32'd256},
    // speed saturates low
    '{12'h001, 8'h07, 4'hf, 32'd2026, 1'b1, 1'b1, 12'h001, 32'd1, 32'h80000000, 32'd256},
    '{12'h001, 8'h08, 4'hf, 32'hffffffff, 1'b0, 1'b0, 12'h0, 32'd0, 32'd0, 32'd0},
    '{12'h002, 8'h09, 4'hf, 32'd0, 1'b0, 1'b0, 12'h0, 32'd0, 32'd0, 32'd0},
    // rejected with counter at its top
    '{12'hfff, 8'hff, 4'hf, 32'd5, 1'b1, 1'b0, 12'h002, 32'd2, 32'd10000000, 32'd501},
    '{12'h000, 8'h00, 4'hf, 32'd0, 1'b0, 1'b0, 12'h0, 32'd0, 32'd0, 32'd0}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  frame_in_t   in_data;
  logic        out_valid;
  logic        out_stall;
  frame_out_t  out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  sent_angle_frame_tracker_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  int          turn_sign;
  int          clip_lo;
  int          clip_hi;
  bit          seen_frame;
  logic [7:0]  next_ctr;
  logic [31:0] missed_sum;
  logic [11:0] last_raw;
  bit          have_raw;
  int          turn_acc;
  logic [31:0] speed_val;
  logic [31:0] last_ts;

  // frame generator state
  logic [7:0]  gen_ctr;
  logic [11:0] gen_ang;
  logic [31:0] gen_ts;

  frame_out_t  expected_reports [$];
  int          mismatch_count;
  int          results_taken;
  bit          long_hold_done;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic reset_tracker();
    turn_sign  = 1;
    clip_lo    = -8388608;
    clip_hi    = 8388607;
    seen_frame = 1'b0;
    next_ctr   = 8'd0;
    missed_sum = 32'd0;
    last_raw   = 12'd0;
    have_raw   = 1'b0;
    turn_acc   = 0;
    speed_val  = 32'd0;
    last_ts    = 32'd0;
  endtask

  function automatic frame_out_t track_frame(frame_in_t f);
    logic [7:0]  ctr;
    logic [7:0]  skipped;
    logic [3:0]  inv;
    logic [11:0] raw;
    logic [31:0] dt;
    longint      delta;
    longint      acc;
    longint      span;
    longint      num;
    longint      quo;
    longint      dtl;
    frame_out_t  r;
    ctr = {f.counter_high_nibble, f.counter_low_nibble};
    next_ctr = next_ctr + 8'd1;
    if (!seen_frame) next_ctr = ctr;
    seen_frame = 1'b1;
    if (ctr != next_ctr) begin
      skipped = ctr - next_ctr;
      missed_sum = missed_sum + {24'd0, skipped};
      next_ctr = ctr;
    end
    inv = ~f.angle_high_nibble;
    r.frame_ok = (inv == f.check_nibble);
    if (r.frame_ok) begin
      raw = {f.angle_high_nibble, f.angle_mid_nibble, f.angle_low_nibble};
      if (have_raw) begin
        delta = longint'(raw) - longint'(last_raw);
        dt = f.timestamp_us - last_ts;
        if (delta > 2048) delta = delta - 4096;
        else if (delta < -2048) delta = delta + 4096;
        acc = longint'(turn_acc);
        acc = acc + delta * turn_sign;
        span = longint'(clip_hi) - clip_lo + 1;
        if (acc < clip_lo) acc = acc + span;
        else if (acc > clip_hi) acc = acc - span;
        turn_acc = acc[31:0];
        if (dt != 32'd0) begin
          dtl = longint'(dt);
          num = 64'sd10000000 * delta * turn_sign;
          quo = num / dtl;
          if (quo > 64'sd2147483647) quo = 64'sd2147483647;
          else if (quo < -64'sd2147483648) quo = -64'sd2147483648;
          speed_val = quo[31:0];
        end
      end
      last_raw = raw;
      have_raw = 1'b1;
      last_ts  = f.timestamp_us;
    end
    r.raw_angle     = last_raw;
    r.turn_angle    = turn_acc;
    r.speed         = speed_val;
    r.missed_frames = missed_sum;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 4);
    else if (r < 98) return $urandom_range(5, 20);
    else return $urandom_range(40, 120);
  endfunction

  // mostly in-sequence frames with small angle steps; some skips, bad checks and jumps
  function automatic frame_in_t make_frame();
    frame_in_t  f;
    int         pick;
    logic [3:0] inv;
    pick = $urandom_range(0, 99);
    if (pick < 88) gen_ctr = gen_ctr + 8'd1;
    else if (pick < 96) gen_ctr = gen_ctr + 8'($urandom_range(2, 20));
    else gen_ctr = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 65) gen_ang = gen_ang + 12'($urandom_range(0, 400)) - 12'd200;
    else if (pick < 80) gen_ang = gen_ang + 12'd2047 + 12'($urandom_range(0, 2));
    else gen_ang = 12'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 70) gen_ts = gen_ts + $urandom_range(1, 2000);
    else if (pick < 80) gen_ts = gen_ts + $urandom_range(1, 3);
    else if (pick >= 88) gen_ts = $urandom;
    {f.angle_high_nibble, f.angle_mid_nibble, f.angle_low_nibble} = gen_ang;
    {f.counter_high_nibble, f.counter_low_nibble} = gen_ctr;
    inv = ~gen_ang[11:8];
    f.check_nibble = ($urandom_range(0, 99) < 88) ? inv : 4'($urandom);
    f.timestamp_us = gen_ts;
    return f;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_count < MaxLines)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_frame(input frame_in_t f, input int gap, input bit typed,
                            input frame_out_t want);
    frame_out_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= f;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = track_frame(f);
    expected_reports.push_back(typed ? want : predicted);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIRECTION: turn_sign = $signed(val[1:0]);
      CFG_RANGE_LOW: clip_lo = val;
      CFG_RANGE_HIGH: clip_hi = val;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    frame_in_t   f;
    probe_row_t  row;
    int          dir;
    logic [31:0] lo;
    logic [31:0] hi;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DIRECTION;
    cfg_data  <= 32'd0;
    mismatch_count = 0;
    reset_tracker();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < $size(ProbeRows); k++) begin
      row = ProbeRows[k];
      f = {row.angle, row.ctr, row.chk, row.ts};
      send_frame(f, pick_gap(), row.typed, {row.ok, row.raw, row.turn, row.spd, row.miss});
    end
    gen_ctr = next_ctr;
    gen_ang = last_raw;
    gen_ts  = last_ts;

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        drain_all();
        if (p < NumFixed) begin
          dir = PhaseDir[p];
          lo  = PhaseLo[p];
          hi  = PhaseHi[p];
        end else begin
          dir = int'($urandom_range(0, 3)) - 2;
          lo  = $urandom;
          hi  = ($urandom_range(0, 1) == 0) ? lo + $urandom_range(0, 20000) : $urandom;
        end
        write_reg(CFG_DIRECTION, 32'(dir));
        write_reg(CFG_RANGE_LOW, lo);
        write_reg(CFG_RANGE_HIGH, hi);
        cfg_valid <= 1'b0;
      end
      for (int k = 0; k < FramesPerPhase; k++)
        send_frame(make_frame(), (k < CalmFrames) ? 0 : pick_gap(), 1'b0, '0);
    end

    drain_all();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off to back up the input
  initial begin : drain_ctl
    int left;
    left = 0;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (left > 0) begin
        left--;
      end else if (!long_hold_done && results_taken >= HoldAfter) begin
        out_stall <= 1'b1;
        left = LongHold;
        long_hold_done = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        left = pick_gap();
      end else begin
        out_stall <= 1'b0;
        left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 6);
      end
    end
  end

  initial results_taken = 0;

  always @(posedge clk) begin
    frame_out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_taken++;
      if (expected_reports.size() == 0) begin
        flag_mismatch("unexpected transaction", out_data.turn_angle, 32'd0);
      end else begin
        want = expected_reports.pop_front();
        if (out_data.frame_ok !== want.frame_ok)
          flag_mismatch("frame_ok", 32'(out_data.frame_ok), 32'(want.frame_ok));
        if (out_data.raw_angle !== want.raw_angle)
          flag_mismatch("raw_angle", 32'(out_data.raw_angle), 32'(want.raw_angle));
        if (out_data.turn_angle !== want.turn_angle)
          flag_mismatch("turn_angle", out_data.turn_angle, want.turn_angle);
        if (out_data.speed !== want.speed)
          flag_mismatch("speed", out_data.speed, want.speed);
        if (out_data.missed_frames !== want.missed_frames)
          flag_mismatch("missed_frames", out_data.missed_frames, want.missed_frames);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> files.f
rtl/saft_pkg.sv
rtl/saft_div.sv
rtl/sent_angle_frame_tracker_core.sv
test/sent_angle_frame_tracker_core_tb.sv
